[rtl/ttcp_pkg.sv]
// Package with the shared constants, codes and result packet type of the table code parser.
package ttcp_pkg;

    localparam int ROWS_DEFAULT         = 7;
    localparam int SYMBOL_COUNT_DEFAULT = 2;

    // Characters of the code format.
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_RIGHT      = 8'h52;
    localparam logic [7:0] CH_LEFT       = 8'h4C;
    localparam logic [7:0] CH_STATE_A    = 8'h41;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;

    // Parse status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_WRITE = 3'd1;
    localparam logic [2:0] ST_BAD_MOVE  = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_BROKEN    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    // Result kinds.
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_WRITE = 4'b0001,
        PH_MOVE  = 4'b0010,
        PH_NEXT  = 4'b0100,
        PH_END   = 4'b1000
    } phase_t;

    // Everything one character can produce: an optional entry and an optional status.
    typedef struct packed {
        logic       has_entry;
        logic [2:0] row_index;
        logic       symbol_index;
        logic [3:0] write_symbol;
        logic       move_right;
        logic       halts;
        logic [2:0] next_row;
        logic       has_status;
        logic [2:0] status;
    } pkt_t;

endpackage

[rtl/ttcp_if.sv]
// Handshake interfaces for the character input channel and the result output channel.
interface ttcp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink (input valid, input ch, input final_char, output ready);
endinterface

interface ttcp_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] row_index;
    logic       symbol_index;
    logic [3:0] write_symbol;
    logic       move_right;
    logic       halts;
    logic [2:0] next_row;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output kind, output row_index, output symbol_index,
                    output write_symbol, output move_right, output halts, output next_row,
                    output status, output last, input ready);
    modport sink (input valid, input kind, input row_index, input symbol_index,
                  input write_symbol, input move_right, input halts, input next_row,
                  input status, input last, output ready);
endinterface

[rtl/ttcp_parse.sv]
// Parse state and per-character decode that turns one character into a result packet.
module ttcp_parse #(
    parameter int ROWS         = ttcp_pkg::ROWS_DEFAULT,
    parameter int SYMBOL_COUNT = ttcp_pkg::SYMBOL_COUNT_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    ch,
    input  logic          fin,
    output ttcp_pkg::pkt_t pkt
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    ttcp_pkg::phase_t phase_reg, phase_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [SW-1:0]    sym_reg, sym_next;
    logic [2:0]       err_reg, err_next;
    logic [3:0]       write_reg, write_next;
    logic             move_reg, move_next;
    logic             is_state;

    assign is_state = (ch >= ttcp_pkg::CH_STATE_A) &&
                      ({1'b0, ch} < ({1'b0, ttcp_pkg::CH_STATE_A} + 9'(ROWS)));

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        sym_next   = sym_reg;
        err_next   = err_reg;
        write_next = write_reg;
        move_next  = move_reg;
        pkt        = '0;

        if (err_reg == ttcp_pkg::ST_OK)
        begin
            case (phase_reg)
                ttcp_pkg::PH_WRITE:
                begin
                    if (ch inside {[ttcp_pkg::CH_DIGIT_0:ttcp_pkg::CH_DIGIT_9]})
                    begin
                        write_next = ch[3:0];
                        phase_next = ttcp_pkg::PH_MOVE;
                    end
                    else if (ch == ttcp_pkg::CH_DASH)
                    begin
                        write_next = 4'd1;
                        phase_next = ttcp_pkg::PH_MOVE;
                    end
                    else
                    begin
                        err_next = ttcp_pkg::ST_BAD_WRITE;
                    end
                end
                ttcp_pkg::PH_MOVE:
                begin
                    if (ch == ttcp_pkg::CH_RIGHT || ch == ttcp_pkg::CH_DASH)
                    begin
                        move_next  = 1'b1;
                        phase_next = ttcp_pkg::PH_NEXT;
                    end
                    else if (ch == ttcp_pkg::CH_LEFT)
                    begin
                        move_next  = 1'b0;
                        phase_next = ttcp_pkg::PH_NEXT;
                    end
                    else
                    begin
                        err_next = ttcp_pkg::ST_BAD_MOVE;
                    end
                end
                ttcp_pkg::PH_NEXT:
                begin
                    pkt.has_entry    = 1'b1;
                    pkt.row_index    = 3'(row_reg);
                    pkt.symbol_index = sym_reg[0];
                    pkt.write_symbol = write_reg;
                    pkt.move_right   = move_reg;
                    pkt.halts        = !is_state;
                    pkt.next_row     = is_state ? 3'(ch - ttcp_pkg::CH_STATE_A) : 3'd0;
                    if ((32'(sym_reg) + 32'd1) < 32'(SYMBOL_COUNT))
                    begin
                        sym_next   = sym_reg + 1'b1;
                        phase_next = ttcp_pkg::PH_WRITE;
                    end
                    else
                    begin
                        phase_next = ttcp_pkg::PH_END;
                    end
                end
                ttcp_pkg::PH_END:
                begin
                    // Anything but an underscore is skipped at the end of a row.
                    if (ch == ttcp_pkg::CH_UNDERSCORE)
                    begin
                        if ((32'(row_reg) + 32'd1) >= 32'(ROWS))
                        begin
                            err_next = ttcp_pkg::ST_TOO_LONG;
                        end
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            sym_next   = '0;
                            phase_next = ttcp_pkg::PH_WRITE;
                        end
                    end
                end
                default:
                begin
                    phase_next = ttcp_pkg::PH_WRITE;
                end
            endcase
        end

        if (fin)
        begin
            pkt.has_status = 1'b1;
            if (err_next != ttcp_pkg::ST_OK)
                pkt.status = err_next;
            else if (32'(row_next) != 32'(ROWS - 1) || 32'(sym_next) != 32'(SYMBOL_COUNT - 1))
                pkt.status = ttcp_pkg::ST_TOO_SHORT;
            else if (phase_next == ttcp_pkg::PH_END)
                pkt.status = ttcp_pkg::ST_OK;
            else
                pkt.status = ttcp_pkg::ST_BROKEN;

            // The final character closes the code; the next one starts a fresh parse.
            phase_next = ttcp_pkg::PH_WRITE;
            row_next   = '0;
            sym_next   = '0;
            err_next   = ttcp_pkg::ST_OK;
            write_next = '0;
            move_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ttcp_pkg::PH_WRITE;
            row_reg   <= '0;
            sym_reg   <= '0;
            err_reg   <= ttcp_pkg::ST_OK;
            write_reg <= '0;
            move_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            sym_reg   <= sym_next;
            err_reg   <= err_next;
            write_reg <= write_next;
            move_reg  <= move_next;
        end
    end

endmodule

[rtl/ttcp_out_fifo.sv]
// Two-deep result packet queue that hands out the entry and status of each packet in turn.
module ttcp_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ttcp_pkg::pkt_t      push_pkt,
    output logic                full,
    ttcp_result_if.source       results
);

    ttcp_pkg::pkt_t mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg, count_next;
    logic           entry_done_reg;
    ttcp_pkg::pkt_t head;
    logic           show_entry;
    logic           out_take;
    logic           pop;

    assign head       = mem[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);
    assign show_entry = head.has_entry && !entry_done_reg;
    assign out_take   = results.valid && results.ready;
    // A packet leaves once its last result is taken.
    assign pop        = out_take && !(show_entry && head.has_status);

    assign results.valid        = (count_reg != 2'd0);
    assign results.kind         = show_entry ? ttcp_pkg::KIND_ENTRY : ttcp_pkg::KIND_STATUS;
    assign results.row_index    = show_entry ? head.row_index : 3'd0;
    assign results.symbol_index = show_entry ? head.symbol_index : 1'b0;
    assign results.write_symbol = show_entry ? head.write_symbol : 4'd0;
    assign results.move_right   = show_entry ? head.move_right : 1'b0;
    assign results.halts        = show_entry ? head.halts : 1'b0;
    assign results.next_row     = show_entry ? head.next_row : 3'd0;
    assign results.status       = show_entry ? ttcp_pkg::ST_OK : head.status;
    assign results.last         = show_entry ? !head.has_status : 1'b1;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_pkt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
            entry_done_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg     <= !rd_ptr_reg;
                entry_done_reg <= 1'b0;
            end
            else if (out_take)
            begin
                entry_done_reg <= 1'b1;
            end
        end
    end

endmodule

[rtl/turing_table_code_parser_unit.sv]
// Top level of the Turing machine table code parser: input register, decode and result queue.
//
//   Port     Direction  Moves per item
//   chars    sink       one code character and its final_char mark
//   results  source     one transition entry or one parse status
//
// Each character is registered, decoded combinationally and queued; the block takes one
// character per cycle unless the queue is full; results drain one per cycle on ready.
// A character that ends a triple and is also final gives two results, which leave the
// result port in turn; the two-deep queue sets how far input runs ahead of output.
// Reset clears the parse state, the input valid flag and the queue.
// A stall on results fills the queue, then chars.ready drops until space returns.
module turing_table_code_parser_unit #(
    parameter int ROWS         = ttcp_pkg::ROWS_DEFAULT,
    parameter int SYMBOL_COUNT = ttcp_pkg::SYMBOL_COUNT_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    ttcp_char_if.sink     chars,
    ttcp_result_if.source results
);

    logic           in_valid_reg;
    logic [7:0]     ch_reg;
    logic           fin_reg;
    logic           fire;
    logic           full;
    logic           in_take;
    logic           push;
    ttcp_pkg::pkt_t pkt;

    assign fire        = in_valid_reg && !full;
    assign chars.ready = !in_valid_reg || fire;
    assign in_take     = chars.valid && chars.ready;
    assign push        = fire && (pkt.has_entry || pkt.has_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg  <= chars.ch;
            fin_reg <= chars.final_char;
        end
    end

    ttcp_parse #(
        .ROWS         (ROWS),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch_reg),
        .fin   (fin_reg),
        .pkt   (pkt)
    );

    ttcp_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (pkt),
        .full     (full),
        .results  (results)
    );

`ifndef SYNTH
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind == ttcp_pkg::KIND_STATUS |-> results.last)
        else $error("status result not marked last");

    a_entry_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind == ttcp_pkg::KIND_ENTRY |->
            results.status == ttcp_pkg::ST_OK)
        else $error("entry result carries a status code");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin_reg |=> results.valid)
        else $error("final character produced no pending result");
`endif

endmodule
